// ===== hw/rtl/tlsf_pkg.sv =====
// Shared types, codes and blend tables for the two-layer sprite framebuffer.
`default_nettype none

package tlsf_pkg;

	localparam int LANES = 8;

	typedef enum logic [1:0] {
		OP_PIXEL  = 2'd0,
		OP_SPRITE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	localparam logic [1:0] BLEND_TAB [0:3][0:15] = '{
		'{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd1,
		  2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0},
		'{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
		  2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1,
		  2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd1},
		'{2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
		  2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2}
	};

	// bit i set: code-0 pixels are drawn for color i
	localparam logic [15:0] OPAQUE_MASK = 16'h7BDF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        to_foreground;
		logic [3:0]  blend_mode;
		logic        mirror_x;
		logic        mirror_y;
		logic [63:0] plane_low;
		logic [63:0] plane_high;
	} item_t;

	typedef struct packed {
		logic        sprite;
		logic        single;
		logic        mirror_x;
		logic        opaque;
		logic [3:0]  color;
		logic [15:0] px;
		logic        row_ok;
		logic [7:0]  lo_byte;
		logic [7:0]  hi_byte;
	} row_t;

	typedef struct packed {
		logic       en;
		logic       wr;
		logic       front;
		logic [1:0] val;
	} bank_ctl_t;

	typedef struct packed {
		logic       changed;
		logic [1:0] pix;
	} bank_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlsf_lane.sv =====
// One pixel lane: clip, decode and blend one sprite column, then form its layer index.
`default_nettype none

module tlsf_lane
	import tlsf_pkg::*;
#(
	parameter int LANE  = 0,
	parameter int IDX_W = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire row_t             row,
	input  wire logic [7:0]       width,
	input  wire logic [IDX_W-1:0] prod_s1,
	output logic                  en,
	output logic [1:0]            val,
	output logic [IDX_W-1:0]      idx
);

	logic [2:0]  off;
	logic [15:0] tx;
	logic [1:0]  code;
	logic        pix_en;
	logic [1:0]  pix_val;
	logic        en_s1;
	logic [1:0]  val_s1;
	logic [7:0]  tx_s1;

	always_comb begin
		off     = row.mirror_x ? 3'(7 - LANE) : 3'(LANE);
		tx      = row.px + {13'd0, off};
		code    = {row.hi_byte[7-LANE], row.lo_byte[7-LANE]};
		pix_en  = row.row_ok && (tx < {8'd0, width}) &&
			(row.sprite ? (row.opaque || code != 2'd0) : (row.single && (LANE == 0)));
		pix_val = row.sprite ? BLEND_TAB[code][row.color] : row.color[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= load && pix_en;
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= pix_val;
		tx_s1  <= tx[7:0];
	end

	assign en  = en_s1;
	assign val = val_s1;
	assign idx = prod_s1 + IDX_W'(tx_s1);

endmodule

`default_nettype wire

// ===== hw/rtl/tlsf_bank.sv =====
// One interleaved pixel bank of both layers with read-compare-write and change detect.
`default_nettype none

module tlsf_bank
	import tlsf_pkg::*;
#(
	parameter int DEPTH = 3200,
	parameter int ENT_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic [ENT_W-1:0] clr_addr,
	input  wire bank_ctl_t        ctl,
	input  wire logic [ENT_W-1:0] addr,
	output bank_res_t             res
);

	logic [1:0]       front_mem [DEPTH];
	logic [1:0]       back_mem  [DEPTH];
	logic [1:0]       f_rd_s2;
	logic [1:0]       b_rd_s2;
	bank_ctl_t        ctl_s2;
	logic [ENT_W-1:0] addr_s2;
	logic [1:0]       cur;
	logic             wr_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr;
	end

	always_comb begin
		cur    = ctl_s2.front ? f_rd_s2 : b_rd_s2;
		wr_hit = ctl_s2.en && ctl_s2.wr && (cur != ctl_s2.val);
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			front_mem[clr_addr] <= 2'd0;
		end else if (wr_hit && ctl_s2.front) begin
			front_mem[addr_s2] <= ctl_s2.val;
		end
		f_rd_s2 <= front_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			back_mem[clr_addr] <= 2'd0;
		end else if (wr_hit && !ctl_s2.front) begin
			back_mem[addr_s2] <= ctl_s2.val;
		end
		b_rd_s2 <= back_mem[addr];
	end

	always_comb begin
		res.changed = wr_hit;
		if (ctl_s2.en && !ctl_s2.wr) begin
			res.pix = (f_rd_s2 != 2'd0) ? f_rd_s2 : b_rd_s2;
		end else begin
			res.pix = 2'd0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/two_layer_sprite_framebuffer.sv =====
// Top level of the two-layer 2-bit sprite framebuffer: control, lane crossbar and merge.
`default_nettype none

// Two 2-bit layers of MAX_WIDTH x MAX_HEIGHT pixels live in eight banks interleaved by
// pixel index, so any run of eight horizontally adjacent pixels touches each bank once.
// After reset a clearing pass zeroes every bank entry, one entry a cycle in all banks;
// s_tready stays low meanwhile. A sprite word is accepted and then runs eight row steps
// (eight lanes read, blend and write one sprite row per cycle through the banks' single
// write port); the lane and bank registers then drain for read and compare-write, and
// the result is posted once the output register is free. A pixel write or a read runs
// a single row step. The result sits in an output register, so the next word is accepted
// while it waits. Configuration is written through cfg_we/cfg_index.
module two_layer_sprite_framebuffer
	import tlsf_pkg::*;
#(
	parameter int MAX_WIDTH  = 160,
	parameter int MAX_HEIGHT = 160
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, to_foreground, blend_mode, mirror_x, mirror_y, two_planes,
	// plane_low, plane_high
	input  wire logic [167:0] s_tdata,
	// opcode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// composed_index, layer_changed, zero fill
	output logic [7:0]        m_tdata,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [7:0]   cfg_wdata
);

	localparam int LAYER_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W      = $clog2(LAYER_SIZE);
	localparam int BANK_DEPTH = (LAYER_SIZE + LANES - 1) / LANES;
	localparam int ENT_W      = IDX_W - 3;
	localparam logic [7:0] W_CAP = 8'((MAX_WIDTH > 255) ? 255 : MAX_WIDTH);
	localparam logic [7:0] H_CAP = 8'((MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT);
	localparam logic [ENT_W-1:0] CLR_LAST = ENT_W'(BANK_DEPTH - 1);

	state_t           state_q;
	state_t           state_d;
	item_t            item_q;
	logic [7:0]       width_q;
	logic [7:0]       height_q;
	logic [7:0]       eff_w;
	logic [7:0]       eff_h;
	logic [2:0]       row_q;
	logic             drain_q;
	logic [ENT_W-1:0] clr_cnt_q;
	logic             acc_changed_q;
	logic [1:0]       acc_pix_q;
	logic             out_valid_q;
	logic [1:0]       out_pix_q;
	logic             out_changed_q;
	logic [IDX_W-1:0] prod_s1;

	logic             clr;
	logic             row_go;
	logic             load_out;
	logic             last_row;
	logic             is_sprite;
	logic [2:0]       v_off;
	logic [15:0]      ty;
	logic [15:0]      prod_full;
	row_t             row;

	logic             lane_en  [LANES];
	logic [1:0]       lane_val [LANES];
	logic [IDX_W-1:0] lane_idx [LANES];
	bank_ctl_t        bank_ctl [LANES];
	logic [ENT_W-1:0] bank_addr [LANES];
	bank_res_t        bank_res [LANES];
	logic             merge_changed;
	logic [1:0]       merge_pix;

	always_comb begin
		eff_w = (width_q == 8'd0) ? 8'd1 : ((width_q > W_CAP) ? W_CAP : width_q);
		eff_h = (height_q == 8'd0) ? 8'd1 : ((height_q > H_CAP) ? H_CAP : height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd160;
			height_q <= 8'd160;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_sprite = (item_q.opcode == OP_SPRITE);
		last_row  = !is_sprite || (row_q == 3'd7);
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		clr      = 1'b0;
		row_go   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr = 1'b1;
				if (clr_cnt_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_ROW;
			end
			ST_ROW: begin
				row_go = 1'b1;
				if (last_row) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			row_q         <= 3'd0;
			drain_q       <= 1'b0;
			acc_changed_q <= 1'b0;
			acc_pix_q     <= 2'd0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (s_tvalid && s_tready) begin
				row_q <= 3'd0;
			end else if (row_go) begin
				row_q <= row_q + 3'd1;
			end
			drain_q <= (state_q == ST_DRAIN) ? !drain_q : 1'b0;
			if (s_tvalid && s_tready) begin
				acc_changed_q <= 1'b0;
				acc_pix_q     <= 2'd0;
			end else begin
				acc_changed_q <= acc_changed_q | merge_changed;
				acc_pix_q     <= acc_pix_q | merge_pix;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.opcode        <= s_tuser;
			item_q.pos_x         <= s_tdata[15:0];
			item_q.pos_y         <= s_tdata[31:16];
			item_q.to_foreground <= s_tdata[32];
			item_q.blend_mode    <= s_tdata[36:33];
			item_q.mirror_x      <= s_tdata[37];
			item_q.mirror_y      <= s_tdata[38];
			item_q.plane_low     <= s_tdata[103:40];
			item_q.plane_high    <= s_tdata[39] ? s_tdata[167:104] : 64'd0;
		end
		if (load_out) begin
			out_pix_q     <= acc_pix_q;
			out_changed_q <= acc_changed_q;
		end
	end

	always_comb begin
		v_off     = (is_sprite && item_q.mirror_y) ? ~row_q : row_q;
		ty        = item_q.pos_y + {13'd0, v_off};
		prod_full = ty[7:0] * eff_w;
		row.sprite   = is_sprite;
		row.single   = (item_q.opcode == OP_PIXEL) || (item_q.opcode == OP_READ);
		row.mirror_x = is_sprite && item_q.mirror_x;
		row.opaque   = OPAQUE_MASK[item_q.blend_mode];
		row.color    = item_q.blend_mode;
		row.px       = item_q.pos_x;
		row.row_ok   = ty < {8'd0, eff_h};
		row.lo_byte  = item_q.plane_low[{row_q, 3'b000} +: 8];
		row.hi_byte  = item_q.plane_high[{row_q, 3'b000} +: 8];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= IDX_W'(prod_full);
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		tlsf_lane #(
			.LANE  (k),
			.IDX_W (IDX_W)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (row_go),
			.row     (row),
			.width   (eff_w),
			.prod_s1 (prod_s1),
			.en      (lane_en[k]),
			.val     (lane_val[k]),
			.idx     (lane_idx[k])
		);
	end

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			bank_ctl[b]       = '0;
			bank_ctl[b].wr    = (item_q.opcode == OP_PIXEL) || is_sprite;
			bank_ctl[b].front = item_q.to_foreground;
			bank_addr[b]      = '0;
			for (int k = 0; k < LANES; k++) begin
				if (lane_en[k] && (lane_idx[k][2:0] == 3'(b))) begin
					bank_ctl[b].en  = 1'b1;
					bank_ctl[b].val = lane_val[k];
					bank_addr[b]    = lane_idx[k][IDX_W-1:3];
				end
			end
		end
	end

	for (genvar b = 0; b < LANES; b++) begin : g_bank
		tlsf_bank #(
			.DEPTH (BANK_DEPTH),
			.ENT_W (ENT_W)
		) u_bank (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (clr),
			.clr_addr (clr_cnt_q),
			.ctl      (bank_ctl[b]),
			.addr     (bank_addr[b]),
			.res      (bank_res[b])
		);
	end

	always_comb begin
		merge_changed = 1'b0;
		merge_pix     = 2'd0;
		for (int b = 0; b < LANES; b++) begin
			merge_changed = merge_changed | bank_res[b].changed;
			merge_pix     = merge_pix | bank_res[b].pix;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_changed_q, out_pix_q};

	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(item_q.opcode == OP_READ && state_q != ST_IDLE && state_q != ST_CLEAR)
			|-> !merge_changed)
		else $error("read word altered a layer");

	a_clear_no_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !(lane_en[0] || lane_en[1] || lane_en[2] ||
			lane_en[3] || lane_en[4] || lane_en[5] || lane_en[6] || lane_en[7]))
		else $error("lane active during clearing pass");

	a_result_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_HOLD)
		else $error("result posted outside hold state");

endmodule

`default_nettype wire
